/* rtl/core/rc4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 cipher package
// Control word layout, sequencer step codes and the microcode table shared by
// the sequencer and the datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int STEP_W = 4;
  localparam int KEY_W  = 64;

  // Configuration register indexes.
  localparam logic [0:0] REG_KEY_LOW  = 1'b0;
  localparam logic [0:0] REG_KEY_HIGH = 1'b1;

  // Program steps.
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_CHECK = 4'd1;
  localparam logic [STEP_W-1:0] ST_CLEAR = 4'd2;
  localparam logic [STEP_W-1:0] ST_FILL  = 4'd3;
  localparam logic [STEP_W-1:0] ST_K1    = 4'd4;
  localparam logic [STEP_W-1:0] ST_K2    = 4'd5;
  localparam logic [STEP_W-1:0] ST_K3    = 4'd6;
  localparam logic [STEP_W-1:0] ST_K4    = 4'd7;
  localparam logic [STEP_W-1:0] ST_PRIME = 4'd8;
  localparam logic [STEP_W-1:0] ST_P1    = 4'd9;
  localparam logic [STEP_W-1:0] ST_P2    = 4'd10;
  localparam logic [STEP_W-1:0] ST_P3    = 4'd11;
  localparam logic [STEP_W-1:0] ST_P4    = 4'd12;
  localparam logic [STEP_W-1:0] ST_P5    = 4'd13;
  localparam logic [STEP_W-1:0] ST_P6    = 4'd14;

  typedef enum logic [1:0] {RA_NONE, RA_I, RA_I_INC, RA_SUM} rd_a_sel_t;
  typedef enum logic [0:0] {RB_NONE, RB_J_NEXT} rd_b_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_FILL, WR_I_DB, WR_J_DA} wr_sel_t;
  typedef enum logic [1:0] {J_HOLD, J_KEY, J_ADD, J_CLEAR} j_op_t;
  typedef enum logic [1:0] {I_HOLD, I_INC, I_CLEAR} i_op_t;
  typedef enum logic [2:0] {
    C_NEXT, C_WAIT_IN, C_JUMP_NORST, C_LOOP, C_OUT, C_JUMP
  } cond_t;

  typedef struct packed {
    rd_a_sel_t         rd_a;
    rd_b_sel_t         rd_b;
    wr_sel_t           wr;
    j_op_t             j_op;
    i_op_t             i_op;
    logic              take_in;
    logic              set_primed;
    logic              load_out;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic restart;
    logic i_last;
    logic out_free;
  } stat_t;

  // Microcode table: one control word per step.
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w.rd_a       = RA_NONE;
    w.rd_b       = RB_NONE;
    w.wr         = WR_NONE;
    w.j_op       = J_HOLD;
    w.i_op       = I_HOLD;
    w.take_in    = 1'b0;
    w.set_primed = 1'b0;
    w.load_out   = 1'b0;
    w.cond       = C_NEXT;
    w.target     = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = C_WAIT_IN;
      end
      ST_CHECK: begin
        w.cond   = C_JUMP_NORST;
        w.target = ST_P1;
      end
      ST_CLEAR: begin
        w.i_op = I_CLEAR;
        w.j_op = J_CLEAR;
      end
      ST_FILL: begin
        w.wr     = WR_FILL;
        w.i_op   = I_INC;
        w.cond   = C_LOOP;
        w.target = ST_FILL;
      end
      ST_K1: begin
        w.rd_a = RA_I;
      end
      ST_K2: begin
        w.j_op = J_KEY;
        w.rd_b = RB_J_NEXT;
      end
      ST_K3: begin
        w.wr = WR_I_DB;
      end
      ST_K4: begin
        w.wr     = WR_J_DA;
        w.i_op   = I_INC;
        w.cond   = C_LOOP;
        w.target = ST_K1;
      end
      ST_PRIME: begin
        w.i_op       = I_CLEAR;
        w.j_op       = J_CLEAR;
        w.set_primed = 1'b1;
      end
      ST_P1: begin
        w.i_op = I_INC;
        w.rd_a = RA_I_INC;
      end
      ST_P2: begin
        w.j_op = J_ADD;
        w.rd_b = RB_J_NEXT;
      end
      ST_P3: begin
        w.wr = WR_I_DB;
      end
      ST_P4: begin
        w.wr = WR_J_DA;
      end
      ST_P5: begin
        w.rd_a = RA_SUM;
      end
      ST_P6: begin
        w.load_out = 1'b1;
        w.cond     = C_OUT;
        w.target   = ST_IDLE;
      end
      default: begin
        w.cond   = C_JUMP;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/rc4_stream_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher, 128-bit key
// Each item's byte is XORed with the next keystream byte. A microcoded
// sequencer steps a small datapath built around a 256-entry permutation RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------
//  in        in_valid / in_stall   data_byte, first_of_message
//  out       out_valid / out_stall result_byte
//  config    cfg_write             cfg_index, cfg_data (key_low, key_high)
//
// Between the acceptance of an item without a restart and the next possible
// acceptance lie one check step, six keystream steps and the idle step
// that takes the next item. The keystream steps are bound by the single write
// port of the permutation RAM, which writes the two halves of a swap in turn.
// A restart (flagged item, or the first item after reset) adds a clear step,
// an identity fill of all 256 entries, steps K1 to K4 of the key schedule for
// each of the 256 entries and one step that zeroes the stream indices.
// The permutation RAM is not cleared by reset; a restart always writes it
// before it is read. in_stall is held high while rst is high. The output
// register holds a finished item while out_stall is high; the sequencer waits
// for it only at its last step.
//
module rc4_stream_cipher (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       first_of_message,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 result_byte,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [rc4_pkg::KEY_W-1:0]  cfg_data
);
  import rc4_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // New items are taken only while the sequencer sits on its idle step and
  // the block is out of reset.
  assign in_stall = ~ctrl.take_in | rst;

  rc4_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rc4_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_byte      (result_byte),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule

/* rtl/core/rc4_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module rc4_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rc4_pkg::stat_t  stat,
  output rc4_pkg::ctrl_t  ctrl
);
  import rc4_pkg::*;

  logic [STEP_W-1:0] upc;
  logic [STEP_W-1:0] upc_next;
  logic [STEP_W-1:0] upc_inc;

  assign ctrl    = rom_word(upc);
  assign upc_inc = STEP_W'(upc + 1'b1);

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:       upc_next = upc_inc;
      C_WAIT_IN:    upc_next = in_valid ? upc_inc : upc;
      C_JUMP_NORST: upc_next = stat.restart ? upc_inc : ctrl.target;
      C_LOOP:       upc_next = stat.i_last ? upc_inc : ctrl.target;
      C_OUT:        upc_next = stat.out_free ? ctrl.target : upc;
      C_JUMP:       upc_next = ctrl.target;
      default:      upc_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

/* rtl/core/rc4_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation memory, stream indexes, key registers and the output register.
// ----------------------------------------------------------------------------
module rc4_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  rc4_pkg::ctrl_t             ctrl,
  output rc4_pkg::stat_t             stat,
  input  logic                       in_valid,
  input  logic [7:0]                 data_byte,
  input  logic                       first_of_message,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 result_byte,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [rc4_pkg::KEY_W-1:0]  cfg_data
);
  import rc4_pkg::*;

  logic [7:0]       perm [256];
  logic [KEY_W-1:0] key_low;
  logic [KEY_W-1:0] key_high;
  logic [7:0]       i;
  logic [7:0]       j;
  logic [7:0]       da;
  logic [7:0]       db;
  logic [7:0]       data;
  logic             first;
  logic             primed;

  logic [KEY_W-1:0] key_word;
  logic [7:0]       key_byte;
  logic [7:0]       j_sum;
  logic [7:0]       i_inc;
  logic [7:0]       rd_a_addr;
  logic [7:0]       wr_addr;
  logic [7:0]       wr_data;
  logic             out_load;

  assign i_inc    = 8'(i + 8'd1);
  assign key_word = i[3] ? key_high : key_low;
  assign key_byte = key_word[{i[2:0], 3'b000} +: 8];
  assign j_sum    = 8'(j + da + ((ctrl.j_op == J_KEY) ? key_byte : 8'd0));

  assign stat.restart  = first | ~primed;
  assign stat.i_last   = (i == 8'hFF);
  assign stat.out_free = ~out_valid | ~out_stall;
  assign out_load      = ctrl.load_out & stat.out_free;

  always_comb begin
    case (ctrl.rd_a)
      RA_I:     rd_a_addr = i;
      RA_I_INC: rd_a_addr = i_inc;
      RA_SUM:   rd_a_addr = 8'(da + db);
      default:  rd_a_addr = i;
    endcase
  end

  always_comb begin
    case (ctrl.wr)
      WR_FILL: begin
        wr_addr = i;
        wr_data = i;
      end
      WR_I_DB: begin
        wr_addr = i;
        wr_data = db;
      end
      default: begin
        wr_addr = j;
        wr_data = da;
      end
    endcase
  end

  // Permutation memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (ctrl.wr != WR_NONE) begin
      perm[wr_addr] <= wr_data;
    end
    if (ctrl.rd_a != RA_NONE) begin
      da <= perm[rd_a_addr];
    end
    if (ctrl.rd_b != RB_NONE) begin
      db <= perm[j_sum];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_in && in_valid) begin
      data <= data_byte;
    end
    if (out_load) begin
      result_byte <= data ^ da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_high  <= '0;
      i         <= '0;
      j         <= '0;
      first     <= 1'b0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_KEY_LOW:  key_low  <= cfg_data;
          REG_KEY_HIGH: key_high <= cfg_data;
          default:      key_low  <= key_low;
        endcase
      end
      if (ctrl.take_in && in_valid) begin
        first <= first_of_message;
      end
      if (ctrl.set_primed) begin
        primed <= 1'b1;
      end
      case (ctrl.i_op)
        I_INC:   i <= i_inc;
        I_CLEAR: i <= '0;
        default: i <= i;
      endcase
      case (ctrl.j_op)
        J_KEY, J_ADD: j <= j_sum;
        J_CLEAR:      j <= '0;
        default:      j <= j;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
